// ===== hdl/qmdn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmdn_pkg
// shared types and constants for the normalised quaternion product pipeline
// ----------------------------------------------------------------------------
package qmdn_pkg;

  localparam int NORM_BITS = 30;
  localparam int SQ_W      = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = NORM_BITS + 1;

  typedef logic [NORM_BITS-1:0] norm_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  // data that rides alongside the square-root and divide stages
  typedef struct packed {
    norm_t [3:0] v;
    logic  [3:0] neg;
    logic        zero;
  } qmeta_t;

  // bit t set: term a[t]*b[c^t] is subtracted for component c
  function automatic logic [3:0] term_neg(op_t op, logic [1:0] c);
    logic [3:0] res;
    res = '0;
    unique case (op)
      OP_MUL: begin
        unique case (c)
          2'd0: res = 4'b1110;
          2'd1: res = 4'b1000;
          2'd2: res = 4'b0010;
          2'd3: res = 4'b0100;
          default: res = '0;
        endcase
      end
      OP_DIV: begin
        unique case (c)
          2'd0: res = 4'b0000;
          2'd1: res = 4'b0110;
          2'd2: res = 4'b1100;
          2'd3: res = 4'b1010;
          default: res = '0;
        endcase
      end
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/qmdn_product.sv =====
// ----------------------------------------------------------------------------
// qmdn_product
// sixteen partial products, then signed sums into four raw components
// ----------------------------------------------------------------------------
module qmdn_product #(
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  qmdn_pkg::op_t        in_op,
  input  logic signed [DW-1:0] in_a [4],
  input  logic signed [DW-1:0] in_b [4],
  output logic                 out_vld,
  output logic signed [2*DW+1:0] out_sum [4],
  output logic                 out_bzero
);
  import qmdn_pkg::*;

  localparam int PW = 2 * DW + 2;

  logic signed [2*DW-1:0] prod_r [4][4];
  op_t                    op_r;
  logic                   bz1_r, bz2_r;
  logic                   v1_r, v2_r;
  logic signed [PW-1:0]   sum_r [4];
  logic signed [PW-1:0]   sum_nxt [4];
  logic                   bz_nxt;

  assign bz_nxt = (in_b[0] == '0) && (in_b[1] == '0) && (in_b[2] == '0) && (in_b[3] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod_r[c][t] <= in_a[t] * in_b[c ^ t];
      end
    end
    op_r  <= in_op;
    bz1_r <= bz_nxt;
  end

  always_comb begin
    logic [3:0]          nm;
    logic signed [PW-1:0] ext;
    for (int c = 0; c < 4; c++) begin
      nm = term_neg(op_r, 2'(c));
      sum_nxt[c] = '0;
      for (int t = 0; t < 4; t++) begin
        ext = PW'(prod_r[c][t]);
        sum_nxt[c] = nm[t] ? (sum_nxt[c] - ext) : (sum_nxt[c] + ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    bz2_r <= bz1_r;
  end

  assign out_vld   = v2_r;
  assign out_sum   = sum_r;
  assign out_bzero = bz2_r;

endmodule

// ===== hdl/qmdn_scale.sv =====
// ----------------------------------------------------------------------------
// qmdn_scale
// magnitudes, common block scale to 30 bits, squares and their sum
// ----------------------------------------------------------------------------
module qmdn_scale #(
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [2*DW+1:0] in_sum [4],
  input  logic                 in_bzero,
  output logic                 out_vld,
  output logic [qmdn_pkg::SQ_W-1:0] out_s,
  output qmdn_pkg::qmeta_t     out_meta
);
  import qmdn_pkg::*;

  localparam int MW = 2 * DW + 1;
  localparam int LW = $clog2(MW + 1);
  localparam int XW = MW + NORM_BITS;
  localparam int SW = $clog2(XW + 1);

  logic          vld3_r, vld4_r, vld5_r, vld6_r, vld7_r;
  logic [MW-1:0] mag3_r [4];
  logic [MW-1:0] mag4_r [4];
  logic [3:0]    neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [MW-1:0] or3_r;
  logic          z3_r, z4_r, z5_r, z6_r, z7_r;
  logic [LW-1:0] len4_r, len_nxt;
  norm_t         v5_r [4];
  norm_t         v6_r [4];
  norm_t         v7_r [4];
  norm_t         v_nxt [4];
  logic [2*NORM_BITS-1:0] sq6_r [4];
  logic [SQ_W-1:0] s7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      vld3_r <= in_vld;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
    end
  end

  // magnitudes and the or of all of them
  always_ff @(posedge clk) begin
    logic [MW-1:0] m;
    logic [MW-1:0] acc;
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      m = in_sum[c][2*DW+1] ? MW'(-in_sum[c]) : MW'(in_sum[c]);
      mag3_r[c] <= m;
      neg3_r[c] <= in_sum[c][2*DW+1];
      acc = acc | m;
    end
    or3_r <= acc;
    z3_r  <= in_bzero;
  end

  // bit length of the largest magnitude
  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < MW; i++) begin
      if (or3_r[i]) len_nxt = LW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    len4_r <= len_nxt;
    mag4_r <= mag3_r;
    neg4_r <= neg3_r;
    z4_r   <= z3_r;
  end

  // bring the top bit of the largest component onto bit 29
  always_comb begin
    logic [SW-1:0] sh;
    logic [XW-1:0] wide;
    for (int c = 0; c < 4; c++) begin
      wide = XW'(mag4_r[c]);
      if (SW'(len4_r) > SW'(NORM_BITS)) begin
        sh = SW'(len4_r) - SW'(NORM_BITS);
        v_nxt[c] = NORM_BITS'(wide >> sh);
      end else begin
        sh = SW'(NORM_BITS) - SW'(len4_r);
        v_nxt[c] = NORM_BITS'(wide << sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    v5_r   <= v_nxt;
    neg5_r <= neg4_r;
    z5_r   <= z4_r | (len4_r == '0);
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      sq6_r[c] <= v5_r[c] * v5_r[c];
    end
    v6_r   <= v5_r;
    neg6_r <= neg5_r;
    z6_r   <= z5_r;
  end

  always_ff @(posedge clk) begin
    s7_r <= SQ_W'(sq6_r[0]) + SQ_W'(sq6_r[1]) + SQ_W'(sq6_r[2]) + SQ_W'(sq6_r[3]);
    v7_r   <= v6_r;
    neg7_r <= neg6_r;
    z7_r   <= z6_r;
  end

  assign out_vld = vld7_r;
  assign out_s   = s7_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      out_meta.v[c] = v7_r[c];
    end
    out_meta.neg  = neg7_r;
    out_meta.zero = z7_r;
  end

endmodule

// ===== hdl/qmdn_sqrt.sv =====
// ----------------------------------------------------------------------------
// qmdn_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module qmdn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [qmdn_pkg::SQ_W-1:0]   in_s,
  input  qmdn_pkg::qmeta_t            in_meta,
  output logic                        out_vld,
  output logic [qmdn_pkg::ROOT_W-1:0] out_root,
  output qmdn_pkg::qmeta_t            out_meta
);
  import qmdn_pkg::*;

  localparam int NSQ = ROOT_W;
  localparam int RW  = NORM_BITS + 4;

  logic              vld_r  [NSQ];
  logic [SQ_W-1:0]   s_r    [NSQ];
  qmeta_t            meta_r [NSQ];
  logic [RW-1:0]     rem_r  [NSQ];
  logic [ROOT_W-1:0] root_r [NSQ];

  for (genvar k = 0; k < NSQ; k++) begin : g_stg
    logic              pv;
    logic [SQ_W-1:0]   ps;
    qmeta_t            pm;
    logic [RW-1:0]     prem;
    logic [ROOT_W-1:0] proot;
    logic [RW-1:0]     rsh;
    logic [RW-1:0]     trial;

    if (k == 0) begin : g_first
      assign pv    = in_vld;
      assign ps    = in_s;
      assign pm    = in_meta;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign pv    = vld_r[k-1];
      assign ps    = s_r[k-1];
      assign pm    = meta_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
    end

    // bring down the next pair of radicand bits
    assign rsh   = {prem[RW-3:0], ps[2*(NSQ-1-k)+1 -: 2]};
    assign trial = RW'({proot, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      s_r[k]    <= ps;
      meta_r[k] <= pm;
      if (rsh >= trial) begin
        rem_r[k]  <= rsh - trial;
        root_r[k] <= {proot[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rsh;
        root_r[k] <= {proot[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld_r[NSQ-1];
  assign out_root = root_r[NSQ-1];
  assign out_meta = meta_r[NSQ-1];

endmodule

// ===== hdl/qmdn_div.sv =====
// ----------------------------------------------------------------------------
// qmdn_div
// four-lane pipelined restoring divide by the norm, rounding and saturation
// ----------------------------------------------------------------------------
module qmdn_div #(
  parameter int DW = 16,
  parameter int FB = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [qmdn_pkg::ROOT_W-1:0] in_len,
  input  qmdn_pkg::qmeta_t            in_meta,
  output logic                        out_vld,
  output logic signed [DW-1:0]        out_q [4],
  output logic                        out_zero
);
  import qmdn_pkg::*;

  localparam int QW  = FB + 1;
  localparam int NDV = QW;
  localparam int DRW = ROOT_W + 1;
  localparam int RMW = DRW + 1;
  localparam int CW  = ((QW > DW) ? QW : DW) + 1;

  logic              vld_r  [NDV];
  qmeta_t            meta_r [NDV];
  logic [ROOT_W-1:0] len_r  [NDV];
  logic [DRW-1:0]    rem_r  [NDV][4];
  logic [QW-1:0]     q_r    [NDV][4];

  logic                 ov_r;
  logic signed [DW-1:0] res_r [4];
  logic                 zero_r;
  logic signed [DW-1:0] res_nxt [4];

  for (genvar k = 0; k < NDV; k++) begin : g_stg
    logic              pv;
    qmeta_t            pm;
    logic [ROOT_W-1:0] pl;
    logic [DRW-1:0]    prem [4];
    logic [QW-1:0]     pq   [4];
    logic [RMW-1:0]    dvs;

    if (k == 0) begin : g_first
      // numerator is 2*v*2^FB + len: high part seeds the remainder
      assign pv = in_vld;
      assign pm = in_meta;
      assign pl = in_len;
      for (genvar c = 0; c < 4; c++) begin : g_seed
        assign prem[c] = DRW'(in_meta.v[c]) + DRW'(in_len >> QW);
        assign pq[c]   = '0;
      end
    end else begin : g_next
      assign pv   = vld_r[k-1];
      assign pm   = meta_r[k-1];
      assign pl   = len_r[k-1];
      assign prem = rem_r[k-1];
      assign pq   = q_r[k-1];
    end

    assign dvs = RMW'({pl, 1'b0});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      logic [RMW-1:0] rsh;
      meta_r[k] <= pm;
      len_r[k]  <= pl;
      for (int c = 0; c < 4; c++) begin
        rsh = {prem[c], pl[QW-1-k]};
        if (rsh >= dvs) begin
          rem_r[k][c] <= DRW'(rsh - dvs);
          q_r[k][c]   <= {pq[c][QW-2:0], 1'b1};
        end else begin
          rem_r[k][c] <= DRW'(rsh);
          q_r[k][c]   <= {pq[c][QW-2:0], 1'b0};
        end
      end
    end
  end

  // saturate to the output range, apply the sign and zero the result when flagged
  always_comb begin
    logic [CW-1:0] qx;
    logic [CW-1:0] lim;
    logic [CW-1:0] sat;
    logic [CW-1:0] sv;
    for (int c = 0; c < 4; c++) begin
      qx  = CW'(q_r[NDV-1][c]);
      lim = meta_r[NDV-1].neg[c] ? (CW'(1) << (DW - 1)) : ((CW'(1) << (DW - 1)) - CW'(1));
      sat = (qx > lim) ? lim : qx;
      sv  = meta_r[NDV-1].neg[c] ? (CW'(0) - sat) : sat;
      res_nxt[c] = meta_r[NDV-1].zero ? '0 : signed'(DW'(sv));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vld_r[NDV-1];
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    zero_r <= meta_r[NDV-1].zero;
  end

  assign out_vld  = ov_r;
  assign out_q    = res_r;
  assign out_zero = zero_r;

endmodule

// ===== hdl/quaternion_mul_div_normalize.sv =====
// ----------------------------------------------------------------------------
// quaternion_mul_div_normalize
// normalised hamilton product or conjugate quotient of two quaternions
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     in_op, in_a_*, in_b_*          start & !busy
//  result    out_r/i/j/k, out_zero_norm     out_valid, one cycle
//
//  one beat enters every cycle; busy is always low
//  the pipeline holds 2 product, 5 scaling, 31 square-root
//  stages, FRAC_BITS + 1 divide stages and the output register
//  the square root and divide run one bit per stage, setting the depth
//  synchronous reset clears the valid bits only; no stalls on either side
// ----------------------------------------------------------------------------
module quaternion_mul_div_normalize #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic signed [DATA_WIDTH-1:0] in_a_r,
  input  logic signed [DATA_WIDTH-1:0] in_a_i,
  input  logic signed [DATA_WIDTH-1:0] in_a_j,
  input  logic signed [DATA_WIDTH-1:0] in_a_k,
  input  logic signed [DATA_WIDTH-1:0] in_b_r,
  input  logic signed [DATA_WIDTH-1:0] in_b_i,
  input  logic signed [DATA_WIDTH-1:0] in_b_j,
  input  logic signed [DATA_WIDTH-1:0] in_b_k,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_r,
  output logic signed [DATA_WIDTH-1:0] out_i,
  output logic signed [DATA_WIDTH-1:0] out_j,
  output logic signed [DATA_WIDTH-1:0] out_k,
  output logic                         out_zero_norm
);
  import qmdn_pkg::*;

  logic signed [DATA_WIDTH-1:0] a_q [4];
  logic signed [DATA_WIDTH-1:0] b_q [4];
  logic                         in_vld;

  logic                           p_vld;
  logic signed [2*DATA_WIDTH+1:0] p_sum [4];
  logic                           p_bzero;

  logic        sc_vld;
  logic [SQ_W-1:0] sc_s;
  qmeta_t      sc_meta;

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  qmeta_t            sq_meta;

  logic signed [DATA_WIDTH-1:0] dv_q [4];

  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  assign a_q[0] = in_a_r;
  assign a_q[1] = in_a_i;
  assign a_q[2] = in_a_j;
  assign a_q[3] = in_a_k;
  assign b_q[0] = in_b_r;
  assign b_q[1] = in_b_i;
  assign b_q[2] = in_b_j;
  assign b_q[3] = in_b_k;

  qmdn_product #(.DW(DATA_WIDTH)) u_product (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .in_op     (op_t'(in_op)),
    .in_a      (a_q),
    .in_b      (b_q),
    .out_vld   (p_vld),
    .out_sum   (p_sum),
    .out_bzero (p_bzero)
  );

  qmdn_scale #(.DW(DATA_WIDTH)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (p_vld),
    .in_sum   (p_sum),
    .in_bzero (p_bzero),
    .out_vld  (sc_vld),
    .out_s    (sc_s),
    .out_meta (sc_meta)
  );

  qmdn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sc_vld),
    .in_s     (sc_s),
    .in_meta  (sc_meta),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_meta (sq_meta)
  );

  qmdn_div #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_len   (sq_root),
    .in_meta  (sq_meta),
    .out_vld  (out_valid),
    .out_q    (dv_q),
    .out_zero (out_zero_norm)
  );

  assign out_r = dv_q[0];
  assign out_i = dv_q[1];
  assign out_j = dv_q[2];
  assign out_k = dv_q[3];

endmodule

// ===== tb/sv/tb_quaternion_mul_div_normalize.sv =====
// ----------------------------------------------------------------------------
// tb_quaternion_mul_div_normalize
// drives quaternion pairs through the normalising product pipeline, predicts
// most results in bit-exact fixed point and checks each in order of arrival
// ----------------------------------------------------------------------------
module tb_quaternion_mul_div_normalize;
  import qmdn_pkg::*;

  localparam int DW = 16;
  localparam int FB = 14;
  localparam int N_RANDOM = 600;
  localparam int LIMIT = 200000;

  typedef logic signed [DW-1:0] comp_t;

  typedef struct {
    op_t   op;
    comp_t a [4];
    comp_t b [4];
  } qpair_t;

  typedef struct {
    comp_t q [4];
    logic  zn;
  } qres_t;

  typedef struct {
    qpair_t pin;
    logic   typed;
    qres_t  res;
  } drow_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  in_op;
  comp_t in_a_r, in_a_i, in_a_j, in_a_k;
  comp_t in_b_r, in_b_i, in_b_j, in_b_k;
  logic  out_valid;
  comp_t out_r, out_i, out_j, out_k;
  logic  out_zero_norm;

  qres_t  pending_q [$];
  drow_t  dir_rows [$];
  int     errors;
  int     n_beats;
  int     n_zero;
  int     cycles;

  quaternion_mul_div_normalize #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op),
    .in_a_r(in_a_r), .in_a_i(in_a_i), .in_a_j(in_a_j), .in_a_k(in_a_k),
    .in_b_r(in_b_r), .in_b_i(in_b_i), .in_b_j(in_b_j), .in_b_k(in_b_k),
    .out_valid(out_valid),
    .out_r(out_r), .out_i(out_i), .out_j(out_j), .out_k(out_k),
    .out_zero_norm(out_zero_norm)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bt;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > s) bt = bt >> 2;
    while (bt != 0) begin
      if (s >= res + bt) begin
        s = s - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // exact component sums, block scaling to 30 bits, then divide by the norm
  function automatic qres_t normalised_product(qpair_t p);
    qres_t r;
    logic signed [63:0] acc [4];
    logic [63:0] mag [4];
    logic [63:0] v [4];
    logic [3:0]  sub;
    logic [63:0] s, len, num, quo, lim;
    logic signed [63:0] prod;
    int maxlen, bl, d;
    logic bzero;
    bzero = 1'b1;
    maxlen = 0;
    s = '0;
    for (int c = 0; c < 4; c++) if (p.b[c] != 0) bzero = 1'b0;
    for (int c = 0; c < 4; c++) begin
      acc[c] = '0;
      for (int t = 0; t < 4; t++) begin
        // subtracted terms per component, hamilton or conjugate form
        if (p.op == OP_MUL)
          sub = (c == 0) ? 4'b1110 : (c == 1) ? 4'b1000 : (c == 2) ? 4'b0010 : 4'b0100;
        else
          sub = (c == 0) ? 4'b0000 : (c == 1) ? 4'b0110 : (c == 2) ? 4'b1100 : 4'b1010;
        prod = 64'(p.a[t]) * 64'(p.b[c ^ t]);
        acc[c] = sub[t] ? acc[c] - prod : acc[c] + prod;
      end
      mag[c] = acc[c] < 0 ? 64'(-acc[c]) : 64'(acc[c]);
      bl = 0;
      for (int k = 0; k < 64; k++) if (mag[c][k]) bl = k + 1;
      if (bl > maxlen) maxlen = bl;
    end
    if (maxlen == 0 || bzero) begin
      for (int c = 0; c < 4; c++) r.q[c] = '0;
      r.zn = 1'b1;
      return r;
    end
    d = maxlen - NORM_BITS;
    for (int c = 0; c < 4; c++) begin
      v[c] = (d > 0) ? mag[c] >> d : mag[c] << (-d);
      s = s + v[c] * v[c];
    end
    len = isqrt(s);
    for (int c = 0; c < 4; c++) begin
      num = (v[c] << FB) * 2 + len;
      quo = num / (2 * len);
      lim = (acc[c] < 0) ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 1);
      if (quo > lim) quo = lim;
      r.q[c] = (acc[c] < 0) ? comp_t'(-quo) : comp_t'(quo);
    end
    r.zn = 1'b0;
    return r;
  endfunction

  function automatic qpair_t mk(op_t op, int ar, int ai, int aj, int ak,
                                int br, int bi, int bj, int bk);
    qpair_t p;
    p.op = op;
    p.a[0] = comp_t'(ar); p.a[1] = comp_t'(ai); p.a[2] = comp_t'(aj); p.a[3] = comp_t'(ak);
    p.b[0] = comp_t'(br); p.b[1] = comp_t'(bi); p.b[2] = comp_t'(bj); p.b[3] = comp_t'(bk);
    return p;
  endfunction

  function automatic qres_t rv(int r0, int r1, int r2, int r3, logic zn);
    qres_t r;
    r.q[0] = comp_t'(r0); r.q[1] = comp_t'(r1); r.q[2] = comp_t'(r2); r.q[3] = comp_t'(r3);
    r.zn = zn;
    return r;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 7))
      0: return comp_t'(-32768);
      1: return comp_t'(32767);
      2: return '0;
      3: return comp_t'(int'($urandom_range(0, 15)) - 8);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic qpair_t rand_pair();
    qpair_t p;
    p.op = op_t'($urandom_range(0, 1));
    for (int c = 0; c < 4; c++) begin
      p.a[c] = rand_comp();
      p.b[c] = rand_comp();
    end
    // now and then an all-zero operand
    if ($urandom_range(0, 19) == 0) for (int c = 0; c < 4; c++) p.b[c] = '0;
    if ($urandom_range(0, 19) == 0) for (int c = 0; c < 4; c++) p.a[c] = '0;
    return p;
  endfunction

  task automatic drive_beat(qpair_t p, logic typed, qres_t tr);
    in_op  <= p.op;
    in_a_r <= p.a[0]; in_a_i <= p.a[1]; in_a_j <= p.a[2]; in_a_k <= p.a[3];
    in_b_r <= p.b[0]; in_b_i <= p.b[1]; in_b_j <= p.b[2]; in_b_k <= p.b[3];
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(typed ? tr : normalised_product(p));
    n_beats++;
    @(negedge clk);
  endtask

  task automatic idle_gap(logic allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    qres_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat r=%0d i=%0d j=%0d k=%0d zn=%0b", $time,
                 out_r, out_i, out_j, out_k, out_zero_norm);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_zero_norm) n_zero++;
        if (out_r !== e.q[0] || out_i !== e.q[1] || out_j !== e.q[2] ||
            out_k !== e.q[3] || out_zero_norm !== e.zn) begin
          $display("%0t: mismatch expected %0d %0d %0d %0d zn=%0b",
                   $time, e.q[0], e.q[1], e.q[2], e.q[3], e.zn);
          $display("%0t:          actual %0d %0d %0d %0d zn=%0b",
                   $time, out_r, out_i, out_j, out_k, out_zero_norm);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL quaternion_mul_div_normalize");
      $finish;
    end
  end

  initial begin
    qres_t none;
    drow_t row;
    int wait_cnt;
    errors = 0; n_beats = 0; n_zero = 0; cycles = 0;
    none = rv(0, 0, 0, 0, 1'b0);
    rst_n = 1'b0; start = 1'b0; in_op = 1'b0;
    in_a_r = '0; in_a_i = '0; in_a_j = '0; in_a_k = '0;
    in_b_r = '0; in_b_i = '0; in_b_j = '0; in_b_k = '0;

    // typed rows: zero cases and unit-basis products; others go to the predictor
    row.typed = 1'b1;
    row.pin = mk(OP_MUL, 0, 0, 0, 0, 0, 0, 0, 0);
    row.res = rv(0, 0, 0, 0, 1); dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 16384, 0, 0, 0, 0, 0, 0, 0);
    row.res = rv(0, 0, 0, 0, 1); dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 0, 0, 0, 0, 16384, 5, 6, 7);
    row.res = rv(0, 0, 0, 0, 1); dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 16384, 0, 0, 0, 16384, 0, 0, 0);
    row.res = rv(16384, 0, 0, 0, 0); dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 0, 16384, 0, 0, 0, 0, 16384, 0);
    row.res = rv(0, 0, 0, 16384, 0); dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 0, 16384, 0, 0, 0, 16384, 0, 0);
    row.res = rv(-16384, 0, 0, 0, 0); dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 16384, 0, 0, 0, 0, 16384, 0, 0);
    row.res = rv(0, 16384, 0, 0, 0); dir_rows.push_back(row);
    row.pin = mk(OP_DIV, -32768, 0, 0, 0, 1, 0, 0, 0);
    row.res = rv(-16384, 0, 0, 0, 0); dir_rows.push_back(row);
    row.typed = 1'b0; row.res = none;
    row.pin = mk(OP_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    dir_rows.push_back(row);
    row.pin = mk(OP_DIV, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
    dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 1, 0, 0, 0, 1, 0, 0, 0);          dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 1, -1, 1, -1, -1, 1, 1, -1);      dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 1, 1, 1, 1, 1, 0, 0, 0);          dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 3, 0, 0, 0, 0, 0, 0, 2);          dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 12000, -7000, 300, 9000, -15000, 4000, 8000, -2000);
    dir_rows.push_back(row);
    row.pin = mk(OP_DIV, 12000, -7000, 300, 9000, -15000, 4000, 8000, -2000);
    dir_rows.push_back(row);
    row.pin = mk(OP_MUL, 32767, 0, 0, 1, 1, 0, 0, 32767);  dir_rows.push_back(row);
    row.pin = mk(OP_DIV, -1, -1, -1, -1, -1, -1, -1, -1);  dir_rows.push_back(row);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[n]) begin
      drive_beat(dir_rows[n].pin, dir_rows[n].typed, dir_rows[n].res);
      idle_gap(1'b1);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      drive_beat(rand_pair(), 1'b0, none);
      idle_gap(n < N_RANDOM - 100);
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (pending_q.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (60) @(posedge clk);
    if (pending_q.size() != 0) begin
      $display("%0d results never arrived", pending_q.size());
      errors++;
    end

    $display("%0d pairs sent, products and quotients, %0d with zero norm flagged",
             n_beats, n_zero);
    if (errors == 0) begin
      $display("PASS quaternion_mul_div_normalize");
    end else begin
      $display("FAIL quaternion_mul_div_normalize");
    end
    $finish;
  end

endmodule
